/* design/stit_pkg.sv */
`default_nettype none

package stit_pkg;

  // Width of every coordinate field on the ports and in the configuration registers.
  localparam int unsigned FIELD_W = 16;

  // Configuration register file.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CFG   = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEG_START_X = 3'd0,
    CFG_SEG_START_Y = 3'd1,
    CFG_SEG_START_Z = 3'd2,
    CFG_SEG_END_X   = 3'd3,
    CFG_SEG_END_Y   = 3'd4,
    CFG_SEG_END_Z   = 3'd5
  } cfg_reg_e;

  // Pipeline stage numbering. Stage k is loaded when adv[k] is set.
  localparam int unsigned NUM_STAGES = 7;
  localparam int unsigned STG_DIFF   = 1;
  localparam int unsigned STG_PROD   = 2;
  localparam int unsigned STG_CROSS  = 3;
  localparam int unsigned STG_PART   = 4;
  localparam int unsigned STG_COMP   = 5;
  localparam int unsigned STG_SIGN   = 6;
  localparam int unsigned STG_OUT    = 7;

  // Sign of an exact integer result; zero is a value of its own.
  typedef enum logic [1:0] {
    SGN_ZERO = 2'b00,
    SGN_POS  = 2'b01,
    SGN_NEG  = 2'b11
  } sgn_e;

  typedef struct packed {
    logic [NUM_STAGES:1] adv;
  } stit_adv_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vert_a_x;
    logic signed [FIELD_W-1:0] vert_a_y;
    logic signed [FIELD_W-1:0] vert_a_z;
    logic signed [FIELD_W-1:0] vert_b_x;
    logic signed [FIELD_W-1:0] vert_b_y;
    logic signed [FIELD_W-1:0] vert_b_z;
    logic signed [FIELD_W-1:0] vert_c_x;
    logic signed [FIELD_W-1:0] vert_c_y;
    logic signed [FIELD_W-1:0] vert_c_z;
  } tri_t;

  typedef struct packed {
    logic hit;
  } res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [FIELD_W-1:0]   wdata;
  } cfg_t;

endpackage

`default_nettype wire

/* design/stit_stream_if.sv */
`default_nettype none

interface stit_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

/* design/stit_cross.sv */
`default_nettype none

// Cross product of two difference vectors over two stages: the six partial
// products are registered first, then the three component differences.
module stit_cross #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  stit_pkg::stit_adv_t            adv_i,
  input  logic signed [COORD_BITS:0]     u_i [3],
  input  logic signed [COORD_BITS:0]     v_i [3],
  output logic signed [2*COORD_BITS+2:0] n_o [3]
);
  import stit_pkg::*;

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;

  logic signed [PW-1:0] prod_d [6];
  logic signed [PW-1:0] prod_q [6];
  logic signed [NW-1:0] n_d [3];
  logic signed [NW-1:0] n_q [3];

  always_comb begin
    prod_d[0] = PW'(u_i[1]) * PW'(v_i[2]);
    prod_d[1] = PW'(u_i[2]) * PW'(v_i[1]);
    prod_d[2] = PW'(u_i[2]) * PW'(v_i[0]);
    prod_d[3] = PW'(u_i[0]) * PW'(v_i[2]);
    prod_d[4] = PW'(u_i[0]) * PW'(v_i[1]);
    prod_d[5] = PW'(u_i[1]) * PW'(v_i[0]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.adv[STG_PROD]) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    n_d[0] = NW'(prod_q[0]) - NW'(prod_q[1]);
    n_d[1] = NW'(prod_q[2]) - NW'(prod_q[3]);
    n_d[2] = NW'(prod_q[4]) - NW'(prod_q[5]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.adv[STG_CROSS]) begin
      n_q <= n_d;
    end
  end

  assign n_o = n_q;

endmodule

`default_nettype wire

/* design/stit_dot.sv */
`default_nettype none

// Sign of dot(d, n) over three stages. Each cross component is split into a
// signed high half and an unsigned low half so that no multiplier exceeds
// roughly (COORD_BITS+1) x (COORD_BITS+3) bits.
module stit_dot #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                           clk_i,
  input  stit_pkg::stit_adv_t            adv_i,
  input  logic signed [COORD_BITS:0]     d_i [3],
  input  logic signed [2*COORD_BITS+2:0] n_i [3],
  output stit_pkg::sgn_e                 sgn_o
);
  import stit_pkg::*;

  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned NW    = 2 * COORD_BITS + 3;
  localparam int unsigned LOW_W = COORD_BITS + 2;
  localparam int unsigned HI_W  = NW - LOW_W;
  localparam int unsigned PLW   = DW + LOW_W + 1;
  localparam int unsigned PHW   = DW + HI_W;
  localparam int unsigned CW    = DW + NW;
  localparam int unsigned SW    = CW + 2;

  logic signed [LOW_W:0]  nlo [3];
  logic signed [HI_W-1:0] nhi [3];
  logic signed [PLW-1:0]  plo_d [3];
  logic signed [PLW-1:0]  plo_q [3];
  logic signed [PHW-1:0]  phi_d [3];
  logic signed [PHW-1:0]  phi_q [3];
  logic signed [CW-1:0]   comp_d [3];
  logic signed [CW-1:0]   comp_q [3];
  logic signed [SW-1:0]   sum;
  sgn_e                   sgn_d;
  sgn_e                   sgn_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nlo[k]   = $signed({1'b0, n_i[k][LOW_W-1:0]});
      nhi[k]   = $signed(n_i[k][NW-1:LOW_W]);
      plo_d[k] = PLW'(d_i[k]) * PLW'(nlo[k]);
      phi_d[k] = PHW'(d_i[k]) * PHW'(nhi[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.adv[STG_PART]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      comp_d[k] = (CW'(phi_q[k]) <<< LOW_W) + CW'(plo_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.adv[STG_COMP]) begin
      comp_q <= comp_d;
    end
  end

  always_comb begin
    sum = SW'(comp_q[0]) + SW'(comp_q[1]) + SW'(comp_q[2]);
    if (sum[SW-1]) begin
      sgn_d = SGN_NEG;
    end else if (|sum) begin
      sgn_d = SGN_POS;
    end else begin
      sgn_d = SGN_ZERO;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.adv[STG_SIGN]) begin
      sgn_q <= sgn_d;
    end
  end

  assign sgn_o = sgn_q;

endmodule

`default_nettype wire

/* design/segment_triangle_intersect_test_unit.sv */
// Segment against triangle intersection test, one triangle per transaction.
// The segment endpoints live in six configuration registers written over
// cfg_i (index 0..2 start x/y/z, 3..5 end x/y/z; other indexes are dropped).
// cfg_i is always ready. Write it only while the pipeline is empty.
// Each vert_i transaction carries the three vertices of a triangle and gives
// exactly one hit_o transaction, in order, with hit set when the segment
// meets the triangle. An endpoint lying in the plane does not reject it, but a
// segment that only grazes an edge or a vertex gets a zero edge sign and
// misses, unless every edge sign is zero.
// The stages from acceptance to hit_o valid are differences, cross-product
// partials, cross components, dot-product partial products, component
// recombination, three-term sum with sign, and the decision. Throughput is
// one transaction per cycle while hit_o is ready; each stage is a register
// with its own valid bit, and a stage loads whenever it is empty or the stage
// after it moves, so bubbles close up while hit_o is stalled. vert_i.ready
// drops only when all seven stages hold a transaction and hit_o is not taken.
// Reset clears every valid bit and sets all segment coordinates to zero.
// Only the low COORD_BITS bits of each field are used, sign-extended.
`default_nettype none

module segment_triangle_intersect_test_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  stit_stream_if.sink       vert_i,
  stit_stream_if.source     hit_o,
  stit_stream_if.sink       cfg_i
);
  import stit_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned NW = 2 * COORD_BITS + 3;

  // Take the low COORD_BITS bits of a field and read them as two's complement.
  function automatic logic signed [CB-1:0] to_coord(input logic [FIELD_W-1:0] f);
    logic [CB-1:0] t;
    t = CB'(f);
    return $signed(t);
  endfunction

  function automatic logic signed [DW-1:0] sub(input logic signed [CB-1:0] x,
                                               input logic signed [CB-1:0] y);
    return DW'(x) - DW'(y);
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [FIELD_W-1:0] seg_q [NUM_CFG];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_CFG; k++) begin
        seg_q[k] <= '0;
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.data.reg_idx)
        CFG_SEG_START_X, CFG_SEG_START_Y, CFG_SEG_START_Z,
        CFG_SEG_END_X, CFG_SEG_END_Y, CFG_SEG_END_Z: begin
          seg_q[cfg_i.data.reg_idx] <= cfg_i.data.wdata;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its successor
  // loads. The chain runs from the output back to the input.
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES:1]   v_q;
  logic [NUM_STAGES:1]   v_d;
  logic [NUM_STAGES:1]   v_prev;
  logic [NUM_STAGES+1:1] rdy;
  stit_adv_t             adv;

  always_comb begin
    rdy[NUM_STAGES+1] = hit_o.ready;
    for (int k = NUM_STAGES; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign adv.adv = rdy[NUM_STAGES:1];
  assign v_prev  = {v_q[NUM_STAGES-1:1], vert_i.valid};
  assign v_d     = (adv.adv & v_prev) | (~adv.adv & v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign vert_i.ready = rdy[STG_DIFF];

  // ---------------------------------------------------------------------------
  // Stage 1: coordinate differences.
  // Cross 0 is the plane normal N = (b-a) x (c-a); crosses 1..3 are
  // (u-s) x (v-s) for the edges (a,b), (b,c) and (c,a).
  // The dot operands are s-a, e-a and e-s.
  // ---------------------------------------------------------------------------
  logic signed [CB-1:0] pa [3];
  logic signed [CB-1:0] pb [3];
  logic signed [CB-1:0] pc [3];
  logic signed [CB-1:0] ps [3];
  logic signed [CB-1:0] pe [3];

  logic signed [DW-1:0] cu_d [4][3];
  logic signed [DW-1:0] cv_d [4][3];
  logic signed [DW-1:0] dd_d [3][3];
  logic signed [DW-1:0] cu_q [4][3];
  logic signed [DW-1:0] cv_q [4][3];
  logic signed [DW-1:0] dd1_q [3][3];
  logic signed [DW-1:0] dd2_q [3][3];
  logic signed [DW-1:0] dd3_q [3][3];

  always_comb begin
    pa[0] = to_coord(vert_i.data.vert_a_x);
    pa[1] = to_coord(vert_i.data.vert_a_y);
    pa[2] = to_coord(vert_i.data.vert_a_z);
    pb[0] = to_coord(vert_i.data.vert_b_x);
    pb[1] = to_coord(vert_i.data.vert_b_y);
    pb[2] = to_coord(vert_i.data.vert_b_z);
    pc[0] = to_coord(vert_i.data.vert_c_x);
    pc[1] = to_coord(vert_i.data.vert_c_y);
    pc[2] = to_coord(vert_i.data.vert_c_z);
    for (int k = 0; k < 3; k++) begin
      ps[k] = to_coord(seg_q[k]);
      pe[k] = to_coord(seg_q[3+k]);
    end
    for (int k = 0; k < 3; k++) begin
      cu_d[0][k] = sub(pb[k], pa[k]);
      cv_d[0][k] = sub(pc[k], pa[k]);
      cu_d[1][k] = sub(pa[k], ps[k]);
      cv_d[1][k] = sub(pb[k], ps[k]);
      cu_d[2][k] = sub(pb[k], ps[k]);
      cv_d[2][k] = sub(pc[k], ps[k]);
      cu_d[3][k] = sub(pc[k], ps[k]);
      cv_d[3][k] = sub(pa[k], ps[k]);
      dd_d[0][k] = sub(ps[k], pa[k]);
      dd_d[1][k] = sub(pe[k], pa[k]);
      dd_d[2][k] = sub(pe[k], ps[k]);
    end
  end

  // Dot operands ride alongside the cross-product stages.
  always_ff @(posedge clk_i) begin
    if (adv.adv[STG_DIFF]) begin
      cu_q  <= cu_d;
      cv_q  <= cv_d;
      dd1_q <= dd_d;
    end
    if (adv.adv[STG_PROD]) begin
      dd2_q <= dd1_q;
    end
    if (adv.adv[STG_CROSS]) begin
      dd3_q <= dd2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 2 and 3: four cross products.
  // ---------------------------------------------------------------------------
  logic signed [NW-1:0] cr [4][3];

  for (genvar g = 0; g < 4; g++) begin : g_cross
    stit_cross #(
      .COORD_BITS (COORD_BITS)
    ) u_cross (
      .clk_i (clk_i),
      .adv_i (adv),
      .u_i   (cu_q[g]),
      .v_i   (cv_q[g]),
      .n_o   (cr[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Stages 4 to 6: five dot-product signs.
  // Signs 0 and 1 are the plane side of the start and end point; signs 2..4
  // are the orientation of the segment against each edge.
  // ---------------------------------------------------------------------------
  sgn_e sgn [5];

  stit_dot #(.COORD_BITS(COORD_BITS)) u_dot_start (
    .clk_i (clk_i), .adv_i (adv), .d_i (dd3_q[0]), .n_i (cr[0]), .sgn_o (sgn[0])
  );

  stit_dot #(.COORD_BITS(COORD_BITS)) u_dot_end (
    .clk_i (clk_i), .adv_i (adv), .d_i (dd3_q[1]), .n_i (cr[0]), .sgn_o (sgn[1])
  );

  stit_dot #(.COORD_BITS(COORD_BITS)) u_dot_edge_ab (
    .clk_i (clk_i), .adv_i (adv), .d_i (dd3_q[2]), .n_i (cr[1]), .sgn_o (sgn[2])
  );

  stit_dot #(.COORD_BITS(COORD_BITS)) u_dot_edge_bc (
    .clk_i (clk_i), .adv_i (adv), .d_i (dd3_q[2]), .n_i (cr[2]), .sgn_o (sgn[3])
  );

  stit_dot #(.COORD_BITS(COORD_BITS)) u_dot_edge_ca (
    .clk_i (clk_i), .adv_i (adv), .d_i (dd3_q[2]), .n_i (cr[3]), .sgn_o (sgn[4])
  );

  // ---------------------------------------------------------------------------
  // Stage 7: decision. Both endpoints strictly on the same side of the plane
  // rejects the triangle; otherwise the signs for edges ab, bc and ca must all
  // agree, with zero treated as a sign of its own.
  // ---------------------------------------------------------------------------
  logic plane_rej;
  logic hit_d;
  logic hit_q;

  always_comb begin
    plane_rej = (sgn[0] != SGN_ZERO) && (sgn[0] == sgn[1]);
    hit_d     = !plane_rej && (sgn[2] == sgn[3]) && (sgn[3] == sgn[4]);
  end

  always_ff @(posedge clk_i) begin
    if (adv.adv[STG_OUT]) begin
      hit_q <= hit_d;
    end
  end

  assign hit_o.valid    = v_q[STG_OUT];
  assign hit_o.data.hit = hit_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_fills_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vert_i.valid && vert_i.ready) |=> v_q[STG_DIFF])
    else $error("accepted transaction did not reach the first stage");

  a_backpressure_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vert_i.ready |-> (&v_q))
    else $error("input stalled while the pipeline has a bubble");

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[STG_OUT] && !hit_o.ready) |=> (v_q[STG_OUT] && $stable(hit_q)))
    else $error("stalled output transaction changed before it was taken");

endmodule

`default_nettype wire
